// ----- sv/byte_pattern_search_all_offsets_macros.svh -----
// Assertion macros shared by the search block.
`ifndef BYTE_PATTERN_SEARCH_ALL_OFFSETS_MACROS_SVH
`define BYTE_PATTERN_SEARCH_ALL_OFFSETS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPSAO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPSAO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bpsao_pkg.sv -----
package bpsao_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int OFFSET_BITS = 32;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int OUT_OFF_W   = 32;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    localparam logic CMD_PATTERN     = 1'b0;
    localparam logic CMD_TEXT        = 1'b1;
    localparam logic KIND_MATCH      = 1'b0;
    localparam logic KIND_SUMMARY    = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_pat;
        logic shift_text;
        logic clear_win;
    } t_cell_ctl;

    typedef struct packed {
        logic                 kind;
        logic [OUT_OFF_W-1:0] offset;
        logic                 found;
        logic                 status;
        logic                 last;
    } t_result;

endpackage

// ----- sv/bpsao_cell.sv -----
module bpsao_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bpsao_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]           i_pat_byte,
    input  logic [7:0]           i_win_byte,
    input  logic                 i_used,
    output logic [7:0]           o_pat_byte,
    output logic [7:0]           o_win_byte,
    output logic                 o_used,
    output logic                 o_hit
);

    logic [7:0] r_pat;
    logic [7:0] r_win;
    logic       r_used;

    // Pattern byte: shifts in reversed order, so this cell lines up with its window tap.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_pat) begin
            r_pat <= i_pat_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= 8'd0;
            r_used <= 1'b0;
        end else begin
            if (i_ctl.clear_win) begin
                r_win <= 8'd0;
            end else if (i_ctl.shift_text) begin
                r_win <= i_win_byte;
            end
            if (i_ctl.shift_pat) begin
                r_used <= i_used;
            end
        end
    end

    // Compare against the byte arriving this cycle, i.e. the window after the shift.
    assign o_hit      = !r_used || (i_win_byte == r_pat);
    assign o_pat_byte = r_pat;
    assign o_win_byte = r_win;
    assign o_used     = r_used;

endmodule

// ----- sv/byte_pattern_search_all_offsets.sv -----
// Byte pattern search: load a pattern of up to 64 bytes (cmd 0, is_last on the final
// byte), then stream text bytes (cmd 1); each offset where the pattern matches the
// newest text bytes gives a match result (only a scan's first unless find_all is
// set), and the last text byte gives a summary (found flag, overflow status) and
// starts a fresh scan. A row of 64 compare cells holds the reversed pattern and the
// text window; each shifts on a byte of its kind, and all cells compare in the cycle
// the byte is taken. One input byte is accepted per clock while the output side takes
// results; a text byte that yields both a match and a summary holds the input until
// the second result drains. find_all takes effect from the next text byte.
module byte_pattern_search_all_offsets (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,   // find_all
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tuser,    // [0] cmd
    input  logic        s_axis_tlast,    // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [31:0] match_offset, [32] found_any,
                                         // [33] status, [39:34] zero
    output logic        m_axis_tuser,    // [0] kind
    output logic        m_axis_tlast     // last_result
);

    localparam int PatMax = bpsao_pkg::PATTERN_MAX;
    localparam int LenW   = bpsao_pkg::LEN_W;
    localparam int OffW   = bpsao_pkg::OFFSET_BITS;
    localparam int OutW   = bpsao_pkg::OUT_OFF_W;

    logic                 r_find_all;
    logic [LenW-1:0]      r_len;
    logic                 r_ovf;
    logic                 r_loading;
    logic [OffW-1:0]      r_count;
    logic                 r_seen;

    logic                 r_v0;
    logic                 r_v1;
    bpsao_pkg::t_result   r_d0;
    bpsao_pkg::t_result   r_d1;

    logic                 s_acc;
    logic                 pop;
    logic                 is_text;
    logic                 is_pat;
    logic                 clr_used;
    logic [LenW-1:0]      base_len;
    bpsao_pkg::t_cell_ctl ctl;

    logic [7:0]           w_pat  [PatMax];
    logic [7:0]           w_win  [PatMax];
    logic [PatMax-1:0]    w_used;
    logic [PatMax-1:0]    w_hit;

    logic [OffW-1:0]      n_count;
    logic                 len_ok;
    logic                 match;
    logic                 rep;
    logic                 have_any;
    logic                 two;
    bpsao_pkg::t_result   res_match;
    bpsao_pkg::t_result   res_sum;
    bpsao_pkg::t_result   res_first;

    assign s_axis_tready = !r_v1 && (!r_v0 || m_axis_tready);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign pop           = r_v0 && m_axis_tready;
    assign is_text       = s_axis_tuser == bpsao_pkg::CMD_TEXT;
    assign is_pat        = s_axis_tuser == bpsao_pkg::CMD_PATTERN;

    // A pattern byte outside a load starts a new pattern.
    assign base_len = r_loading ? r_len : '0;
    assign clr_used = s_acc && is_pat && !r_loading;

    always_comb begin
        ctl.shift_pat  = s_acc && is_pat && (base_len < LenW'(PatMax));
        ctl.shift_text = s_acc && is_text;
        ctl.clear_win  = clr_used || (s_acc && is_text && s_axis_tlast);
    end

    for (genvar g = 0; g < PatMax; g++) begin : g_cell
        logic [7:0] pat_in;
        logic [7:0] win_in;
        logic       used_in;

        if (g == 0) begin : g_head
            assign pat_in  = s_axis_tdata;
            assign win_in  = s_axis_tdata;
            assign used_in = 1'b1;
        end else begin : g_body
            assign pat_in  = w_pat[g-1];
            assign win_in  = w_win[g-1];
            assign used_in = w_used[g-1] && !clr_used;
        end

        bpsao_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_pat_byte (pat_in),
            .i_win_byte (win_in),
            .i_used     (used_in),
            .o_pat_byte (w_pat[g]),
            .o_win_byte (w_win[g]),
            .o_used     (w_used[g]),
            .o_hit      (w_hit[g])
        );
    end

    assign n_count = (r_count == bpsao_pkg::COUNT_MAX) ? r_count : r_count + OffW'(1);
    assign len_ok  = (r_len != '0) && !r_ovf && (n_count >= OffW'(r_len));
    assign match   = is_text && len_ok && (&w_hit);
    assign rep     = match && (r_find_all || !r_seen);

    always_comb begin
        res_match.kind   = bpsao_pkg::KIND_MATCH;
        res_match.offset = OutW'(n_count - OffW'(r_len));
        res_match.found  = 1'b1;
        res_match.status = bpsao_pkg::STATUS_OK;
        res_match.last   = !s_axis_tlast;

        res_sum.kind     = bpsao_pkg::KIND_SUMMARY;
        res_sum.offset   = '0;
        res_sum.found    = r_seen || match;
        res_sum.status   = r_ovf ? bpsao_pkg::STATUS_OVERFLOW : bpsao_pkg::STATUS_OK;
        res_sum.last     = 1'b1;

        res_first = rep ? res_match : res_sum;
        have_any  = is_text && (rep || s_axis_tlast);
        two       = is_text && rep && s_axis_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_all <= 1'b0;
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_loading  <= 1'b0;
            r_count    <= '0;
            r_seen     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_find_all <= i_cfg_wr_data;
            end
            if (s_acc && is_pat) begin
                if (base_len < LenW'(PatMax)) begin
                    r_len <= base_len + LenW'(1);
                    r_ovf <= r_loading && r_ovf;
                end else begin
                    r_len <= base_len;
                    r_ovf <= 1'b1;
                end
                r_loading <= !s_axis_tlast;
                if (!r_loading) begin
                    r_count <= '0;
                    r_seen  <= 1'b0;
                end
            end else if (s_acc && is_text) begin
                r_loading <= 1'b0;
                if (s_axis_tlast) begin
                    r_count <= '0;
                    r_seen  <= 1'b0;
                end else begin
                    r_count <= n_count;
                    r_seen  <= r_seen || match;
                end
            end
        end
    end

    // Two-entry result queue: head drives the output, second holds a trailing summary.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (s_acc && have_any) begin
            r_v0 <= 1'b1;
            r_v1 <= two;
        end else if (pop) begin
            r_v0 <= r_v1;
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && have_any) begin
            r_d0 <= res_first;
            r_d1 <= res_sum;
        end else if (pop) begin
            r_d0 <= r_d1;
        end
    end

    assign m_axis_tvalid = r_v0;
    assign m_axis_tuser  = r_d0.kind;
    assign m_axis_tlast  = r_d0.last;
    assign m_axis_tdata  = {6'd0, r_d0.status, r_d0.found, r_d0.offset};

`include "byte_pattern_search_all_offsets_macros.svh"

    `BPSAO_ASSERT_NOW(a_queue_order, i_clk, i_rst_n, r_v1, r_v0,
        "second result slot filled while head is empty")
    `BPSAO_ASSERT_NOW(a_summary_last, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser == bpsao_pkg::KIND_SUMMARY), m_axis_tlast,
        "summary result without last flag")
    `BPSAO_ASSERT_NOW(a_ovf_len, i_clk, i_rst_n, r_ovf, r_len == LenW'(PatMax),
        "overflow set with pattern length below store size")
    `BPSAO_ASSERT_NEXT(a_scan_restart, i_clk, i_rst_n,
        s_acc && is_text && s_axis_tlast, (r_count == '0) && !r_seen,
        "scan state not cleared after last text byte")

endmodule

// ----- sim/byte_pattern_search_all_offsets_tb.sv -----
`timescale 1ns / 1ps

module byte_pattern_search_all_offsets_tb;
    import bpsao_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_TARGET = 600;
    localparam int MAX_IDLE = 11;
    localparam int TEXT_BUF = 100;

    typedef enum logic {ROW_XFER, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op op;
        logic    cmd;
        logic [7:0] data;
        logic    lst;
        bit      typed;
        t_result res;
    } t_dir_row;

    localparam t_result NO_RES = '0;
    localparam t_result HIT_AT0 = '{KIND_MATCH, 32'd0, 1'b1, STATUS_OK, 1'b1};
    localparam t_result SUM_NONE = '{KIND_SUMMARY, 32'd0, 1'b0, STATUS_OK, 1'b1};
    localparam t_result SUM_FOUND = '{KIND_SUMMARY, 32'd0, 1'b1, STATUS_OK, 1'b1};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] cmd
    logic        s_axis_tlast = 1'b0;    // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [31:0] match_offset, [32] found_any,
                                         // [33] status, [39:34] zero
    logic        m_axis_tuser;           // [0] kind
    logic        m_axis_tlast;           // last_result

    // Sideband that travels with the byte on the input: a typed-in expectation.
    bit      cur_typed = 1'b0;
    t_result cur_res = '0;

    bit snd_idle_on = 1'b1;
    bit rcv_idle_on = 1'b1;
    int rcv_wait = 0;
    int items_sent = 0;
    int errors = 0;
    int cycles = 0;

    t_result hits_due [$];
    t_result step_res [$];

    // Search model state
    logic [7:0]             pat_mem [PATTERN_MAX];
    logic [7:0]             win [PATTERN_MAX];
    int unsigned            pat_len = 0;
    bit                     pat_ovf = 1'b0;
    logic [OFFSET_BITS-1:0] txt_cnt = '0;
    bit                     hit_seen = 1'b0;
    bit                     loading = 1'b0;
    bit                     find_all_m = 1'b0;

    t_dir_row dir_rows [21] = '{
        '{ROW_XFER, CMD_TEXT,    8'h00, 1'b1, 1'b1, SUM_NONE},
        '{ROW_XFER, CMD_PATTERN, 8'h00, 1'b1, 1'b0, NO_RES},
        '{ROW_XFER, CMD_TEXT,    8'h00, 1'b0, 1'b1, HIT_AT0},
        '{ROW_XFER, CMD_TEXT,    8'hFF, 1'b0, 1'b0, NO_RES},
        '{ROW_XFER, CMD_TEXT,    8'h00, 1'b1, 1'b1, SUM_FOUND},
        '{ROW_CFG,  1'b0,        8'h01, 1'b0, 1'b0, NO_RES},
        '{ROW_XFER, CMD_PATTERN, 8'hFF, 1'b0, 1'b0, NO_RES},
        '{ROW_XFER, CMD_PATTERN, 8'h00, 1'b1, 1'b0, NO_RES},
        '{ROW_XFER, CMD_TEXT,    8'hFF, 1'b0, 1'b0, NO_RES},
        '{ROW_XFER, CMD_TEXT,    8'h00, 1'b0, 1'b1, HIT_AT0},
        '{ROW_XFER, CMD_TEXT,    8'hFF, 1'b0, 1'b0, NO_RES},
        '{ROW_XFER, CMD_TEXT,    8'h00, 1'b1, 1'b0, NO_RES},
        '{ROW_XFER, CMD_PATTERN, 8'hA5, 1'b0, 1'b0, NO_RES},
        '{ROW_XFER, CMD_TEXT,    8'hA5, 1'b1, 1'b0, NO_RES},
        '{ROW_XFER, CMD_PATTERN, 8'h5A, 1'b1, 1'b0, NO_RES},
        '{ROW_XFER, CMD_TEXT,    8'h5A, 1'b0, 1'b1, HIT_AT0},
        '{ROW_XFER, CMD_PATTERN, 8'h5A, 1'b1, 1'b0, NO_RES},
        '{ROW_XFER, CMD_TEXT,    8'h00, 1'b1, 1'b1, SUM_NONE},
        '{ROW_CFG,  1'b0,        8'h00, 1'b0, 1'b0, NO_RES},
        '{ROW_XFER, CMD_TEXT,    8'h5A, 1'b0, 1'b1, HIT_AT0},
        '{ROW_XFER, CMD_TEXT,    8'h5A, 1'b1, 1'b1, SUM_FOUND}
    };

    byte_pattern_search_all_offsets dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_scan();
        foreach (win[i]) win[i] = 8'h00;
        txt_cnt = '0;
        hit_seen = 1'b0;
    endfunction

    // Advance the search state by one byte; results land in step_res.
    function automatic void search_byte(logic cmd, logic [7:0] b, logic lst);
        bit hit;
        bit report;
        t_result r;
        step_res.delete();
        if (cmd == CMD_PATTERN) begin
            if (!loading) begin
                pat_len = 0;
                pat_ovf = 1'b0;
                clear_scan();
            end
            if (pat_len < PATTERN_MAX) begin
                pat_mem[pat_len] = b;
                pat_len++;
            end else begin
                pat_ovf = 1'b1;
            end
            loading = !lst;
            return;
        end
        loading = 1'b0;
        for (int i = PATTERN_MAX - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (txt_cnt != COUNT_MAX) txt_cnt++;
        hit = pat_len != 0 && !pat_ovf && txt_cnt >= pat_len;
        for (int i = 0; i < pat_len; i++) begin
            if (win[i] != pat_mem[pat_len-1-i]) hit = 1'b0;
        end
        if (hit) begin
            report = find_all_m || !hit_seen;
            hit_seen = 1'b1;
            if (report) begin
                r.kind = KIND_MATCH;
                r.offset = 32'(txt_cnt - pat_len);
                r.found = 1'b1;
                r.status = STATUS_OK;
                r.last = !lst;
                step_res = {step_res, r};
            end
        end
        if (lst) begin
            r.kind = KIND_SUMMARY;
            r.offset = '0;
            r.found = hit_seen;
            r.status = pat_ovf ? STATUS_OVERFLOW : STATUS_OK;
            r.last = 1'b1;
            step_res = {step_res, r};
            clear_scan();
        end
    endfunction

    function automatic void flag_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: result %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Sink side: random stall after each result transfer.
    always @(posedge i_clk) begin
        int w;
        if (rcv_wait > 0) begin
            rcv_wait--;
            if (rcv_wait == 0) m_axis_tready <= 1'b1;
        end else if (m_axis_tready && m_axis_tvalid) begin
            w = rcv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                rcv_wait = w;
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Track accepted bytes and config writes, check every result transfer.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("byte_pattern_search_all_offsets verification failed");
                $finish;
            end
            if (i_cfg_wr_en) find_all_m = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                search_byte(s_axis_tuser, s_axis_tdata, s_axis_tlast);
                if (cur_typed) hits_due = {hits_due, cur_res};
                else hits_due = {hits_due, step_res};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (hits_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual kind %0h offset %0h",
                             $time, m_axis_tuser, m_axis_tdata[31:0]);
                    errors++;
                end else begin
                    want = hits_due.pop_front();
                    flag_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                    flag_field("match_offset", want.offset, m_axis_tdata[31:0]);
                    flag_field("found_any", 32'(want.found), 32'(m_axis_tdata[32]));
                    flag_field("status", 32'(want.status), 32'(m_axis_tdata[33]));
                    flag_field("last_result", 32'(want.last), 32'(m_axis_tlast));
                    flag_field("pad", 32'd0, 32'(m_axis_tdata[39:34]));
                end
            end
        end
    end

    task automatic send_byte(logic cmd, logic [7:0] b, logic lst, bit typed, t_result res);
        int gap;
        gap = snd_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= cmd;
        s_axis_tlast <= lst;
        cur_typed <= typed;
        cur_res <= res;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Hold the input until every result is back, then let the pipeline settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (hits_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic fa);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= fa;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte(logic [7:0] a0, logic [7:0] a1);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'($urandom_range(0, 255));
        return (r < 4) ? a0 : a1;
    endfunction

    initial begin : stimulus
        logic [7:0] pat_bytes [TEXT_BUF];
        logic [7:0] txt_bytes [TEXT_BUF];
        logic [7:0] a0, a1;
        int plen, tlen, pos, seq;
        bit broken, abandon;

        plen = 0;
        seq = 0;
        a0 = 8'h00;
        a1 = 8'hFF;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) write_mode(dir_rows[i].data[0]);
            else send_byte(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].lst,
                           dir_rows[i].typed, dir_rows[i].res);
        end

        while (items_sent < ITEM_TARGET) begin
            snd_idle_on = ($urandom_range(0, 3) != 0);
            rcv_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));

            // New pattern: first a full-store one, then an overflowing one, then mostly short.
            if (seq < 2 || $urandom_range(0, 1) == 0) begin
                a0 = 8'($urandom_range(0, 255));
                a1 = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                                 : a0 ^ (8'h01 << $urandom_range(0, 7));
                if (seq == 0) plen = PATTERN_MAX;
                else if (seq == 1) plen = PATTERN_MAX + 2;
                else if ($urandom_range(0, 15) == 0) plen = PATTERN_MAX + $urandom_range(0, 4);
                else plen = $urandom_range(1, 6);
                broken = ($urandom_range(0, 7) == 0);
                for (int i = 0; i < plen; i++) begin
                    pat_bytes[i] = pick_byte(a0, a1);
                    send_byte(CMD_PATTERN, pat_bytes[i], i == plen - 1 && !broken,
                              1'b0, NO_RES);
                end
            end

            tlen = (plen > 6 ? plen : 0) + $urandom_range(1, 24);
            if (tlen > TEXT_BUF) tlen = TEXT_BUF;
            for (int i = 0; i < tlen; i++) txt_bytes[i] = pick_byte(a0, a1);
            if (plen > 0 && plen <= tlen && $urandom_range(0, 1) != 0) begin
                pos = $urandom_range(0, tlen - plen);
                for (int i = 0; i < plen; i++) txt_bytes[pos + i] = pat_bytes[i];
            end
            // Now and then leave the scan open so a following pattern restarts it.
            abandon = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < tlen; i++) begin
                send_byte(CMD_TEXT, txt_bytes[i], i == tlen - 1 && !abandon, 1'b0, NO_RES);
            end
            seq++;
        end

        wait_drained();
        if (errors == 0) begin
            $display("byte_pattern_search_all_offsets verification clean");
        end else begin
            $display("byte_pattern_search_all_offsets verification failed");
        end
        $finish;
    end

endmodule
